// File: rtl/fbm_value_noise_terrain_height_top_macros.svh
`ifndef FBM_VALUE_NOISE_TERRAIN_HEIGHT_TOP_MACROS_SVH
`define FBM_VALUE_NOISE_TERRAIN_HEIGHT_TOP_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define FBM_ASSERT_IMP(label, a, c) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("fbm assertion failed");

// next-cycle implication, clocked on aclk, off during reset
`define FBM_ASSERT_NXT(label, a, c) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("fbm assertion failed");

`endif

// File: rtl/fbmvn_pkg.sv
`default_nettype none

package fbmvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int OCT_W       = 4;
    localparam int FREQ_W      = 24;
    localparam int FRAC_W      = 16;
    localparam int HASH_W      = 31;
    localparam int PROD_W      = 32 + FREQ_W + 1;
    localparam int CELL_SHIFT  = 36;
    localparam int NOISE_DEPTH = 6;
    localparam int LAYER_DEPTH = 1 + NOISE_DEPTH + 4;
    localparam int DIV_STEPS   = 16;
    localparam int HILL_DELAY  = 1 + DIV_STEPS + 2;
    localparam int SHAPE_DEPTH = HILL_DELAY + 2;
    localparam int PIPE_DEPTH  = LAYER_DEPTH + SHAPE_DEPTH;

    localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
    localparam logic [31:0] HASH_MUL_Z   = 32'd668265263;
    localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;

    typedef enum logic [2:0] {
        CFG_MASK_FREQ      = 3'd0,
        CFG_HILL_FREQ      = 3'd1,
        CFG_MASK_OCTAVES   = 3'd2,
        CFG_HILL_OCTAVES   = 3'd3,
        CFG_PEAK_HEIGHT    = 3'd4,
        CFG_MASK_EDGE_LOW  = 3'd5,
        CFG_MASK_EDGE_HIGH = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        T_ZERO,
        T_FULL,
        T_DIV
    } t_sel_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [OCT_W-1:0]  octaves;
    } layer_cfg_t;

    typedef struct packed {
        logic [15:0] edge_low;
        logic [15:0] edge_high;
        logic [15:0] peak;
    } shape_cfg_t;

    // normalizing reciprocal of (1 - 2^-n) in Q2.30
    function automatic logic [31:0] recip_q30(input logic [OCT_W-1:0] n);
        logic [31:0] r;
        case (n)
            4'd1:    r = 32'd2147483648;
            4'd2:    r = 32'd1431655765;
            4'd3:    r = 32'd1227133513;
            4'd4:    r = 32'd1145324612;
            4'd5:    r = 32'd1108378657;
            4'd6:    r = 32'd1090785345;
            4'd7:    r = 32'd1082196484;
            4'd8:    r = 32'd1077952576;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [OCT_W-1:0] sat_octaves(input logic [OCT_W-1:0] n);
        logic [OCT_W-1:0] r;
        r = (n > OCT_W'(MAX_OCTAVES)) ? OCT_W'(MAX_OCTAVES) : n;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/fbm_value_noise_terrain_height_top.sv
// terrain height from two fractal value-noise layers (mask and hills)
// 32 register stages from input transfer to the output register
// throughput: one sample per cycle while the skid entry is free, every stage advances together on one enable
// a one-entry skid register behind the output keeps input open while a result waits, until the skid entry is full
// reset: aresetn synchronous active low, clears valid bits and loads register defaults
`default_nettype none

`include "fbm_value_noise_terrain_height_top_macros.svh"

module fbm_value_noise_terrain_height_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_world_x,
    input  logic signed [31:0] s_world_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [16:0] m_height,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_wdata
);
    import fbmvn_pkg::*;

    // configuration registers
    logic [FREQ_W-1:0] mask_freq_reg, hill_freq_reg;
    logic [OCT_W-1:0]  mask_oct_reg, hill_oct_reg;
    logic [15:0]       peak_reg, edge_low_reg, edge_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_freq_reg <= 24'd111848;
            hill_freq_reg <= 24'd186414;
            mask_oct_reg  <= 4'd3;
            hill_oct_reg  <= 4'd4;
            peak_reg      <= 16'd4608;
            edge_low_reg  <= 16'd22938;
            edge_high_reg <= 16'd42598;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MASK_FREQ:      mask_freq_reg <= cfg_wdata;
                CFG_HILL_FREQ:      hill_freq_reg <= cfg_wdata;
                CFG_MASK_OCTAVES:   mask_oct_reg  <= cfg_wdata[OCT_W-1:0];
                CFG_HILL_OCTAVES:   hill_oct_reg  <= cfg_wdata[OCT_W-1:0];
                CFG_PEAK_HEIGHT:    peak_reg      <= cfg_wdata[15:0];
                CFG_MASK_EDGE_LOW:  edge_low_reg  <= cfg_wdata[15:0];
                CFG_MASK_EDGE_HIGH: edge_high_reg <= cfg_wdata[15:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    layer_cfg_t mask_cfg, hill_cfg;
    shape_cfg_t shp_cfg;

    assign mask_cfg = '{freq: mask_freq_reg, octaves: mask_oct_reg};
    assign hill_cfg = '{freq: hill_freq_reg, octaves: hill_oct_reg};
    assign shp_cfg  = '{edge_low: edge_low_reg, edge_high: edge_high_reg, peak: peak_reg};

    // output register and skid entry state
    logic               m_valid_reg, skid_valid_reg;
    logic signed [16:0] m_height_reg, skid_height_reg;
    logic               out_stall;

    // whole pipeline moves while the skid entry is free
    logic en;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    // valid bits run beside the datapath
    logic [PIPE_DEPTH-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // two fractal layers sharing the input coordinate
    logic signed [31:0] mask_raw, hills;

    fbmvn_layer u_mask (
        .aclk  (aclk),
        .en    (en),
        .x     (s_world_x),
        .z     (s_world_z),
        .cfg   (mask_cfg),
        .value (mask_raw)
    );

    fbmvn_layer u_hill (
        .aclk  (aclk),
        .en    (en),
        .x     (s_world_x),
        .z     (s_world_z),
        .cfg   (hill_cfg),
        .value (hills)
    );

    // smoothstep mask, divider and height scaling
    logic signed [16:0] pipe_height;

    fbmvn_shape u_shape (
        .aclk     (aclk),
        .en       (en),
        .mask_raw (mask_raw),
        .hills    (hills),
        .cfg      (shp_cfg),
        .height   (pipe_height)
    );

    logic pipe_valid;
    assign pipe_valid = valid_reg[PIPE_DEPTH-1];

    // output register with one skid entry
    assign out_stall = m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_stall) begin
            if (en && pipe_valid) skid_valid_reg <= 1'b1;
        end else if (skid_valid_reg) begin
            m_valid_reg    <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= pipe_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_stall) begin
            if (en && pipe_valid) skid_height_reg <= pipe_height;
        end else if (skid_valid_reg) begin
            m_height_reg <= skid_height_reg;
        end else begin
            m_height_reg <= pipe_height;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_height = m_height_reg;

    // a held skid entry always sits behind a waiting result
    `FBM_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    // a finished sample arriving at a stalled output is caught by the skid entry
    `FBM_ASSERT_NXT(a_skid_catch, out_stall && en && pipe_valid, skid_valid_reg && m_valid_reg)
    // a finished sample with a free path reaches the output next cycle
    `FBM_ASSERT_NXT(a_pipe_to_out, pipe_valid && en && !out_stall, m_valid_reg)

endmodule

`default_nettype wire

// File: rtl/fbmvn_noise.sv
`default_nettype none

module fbmvn_noise (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] cell_x,
    input  logic [31:0] cell_z,
    input  logic [15:0] frac_x,
    input  logic [15:0] frac_z,
    output logic [30:0] value
);
    import fbmvn_pkg::*;

    // stage 1: lattice multiplies, fraction square
    logic [31:0] xa_reg, zb_reg;
    logic [15:0] u1_reg [2];
    logic [31:0] usq_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            xa_reg     <= cell_x * HASH_MUL_X;
            zb_reg     <= cell_z * HASH_MUL_Z;
            u1_reg[0]  <= frac_x;
            u1_reg[1]  <= frac_z;
            usq_reg[0] <= 32'(frac_x) * 32'(frac_x);
            usq_reg[1] <= 32'(frac_z) * 32'(frac_z);
        end
    end

    // stage 2: corner sums and first xor-shift, fade polynomial
    logic [31:0] corner [4];
    logic [31:0] mix_next [4];
    logic [37:0] q_full [2];
    logic [31:0] mix_reg [4];
    logic [20:0] q16_reg [2];
    logic [15:0] u2s_reg [2];
    logic [15:0] u2_reg [2];

    always_comb begin
        corner[0] = xa_reg + zb_reg;
        corner[1] = corner[0] + HASH_MUL_X;
        corner[2] = corner[0] + HASH_MUL_Z;
        corner[3] = corner[1] + HASH_MUL_Z;
        for (int j = 0; j < 4; j++) begin
            mix_next[j] = corner[j] ^ 32'($signed(corner[j]) >>> 13);
        end
        for (int k = 0; k < 2; k++) begin
            q_full[k] = 38'(usq_reg[k]) * 38'd6 + (38'd10 << 32)
                      - ((38'(u1_reg[k]) * 38'd15) << 16);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) mix_reg[j] <= mix_next[j];
            for (int k = 0; k < 2; k++) begin
                q16_reg[k] <= q_full[k][36:16];
                u2s_reg[k] <= usq_reg[k][31:16];
                u2_reg[k]  <= u1_reg[k];
            end
        end
    end

    // stage 3: mixing multiply, cube of fraction
    logic [31:0] hmix_reg [4];
    logic [15:0] u3_reg [2];
    logic [20:0] q16b_reg [2];
    logic [31:0] u3_full [2];

    always_comb begin
        for (int k = 0; k < 2; k++) u3_full[k] = 32'(u2s_reg[k]) * 32'(u2_reg[k]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) hmix_reg[j] <= mix_reg[j] * HASH_MUL_MIX;
            for (int k = 0; k < 2; k++) begin
                u3_reg[k]   <= u3_full[k][31:16];
                q16b_reg[k] <= q16_reg[k];
            end
        end
    end

    // stage 4: final xor-shift, fade weight
    logic [31:0] hfin [4];
    logic [36:0] s_full [2];
    logic [HASH_W-1:0] hash_reg [4];
    logic [16:0] s_reg [2];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            hfin[j] = hmix_reg[j] ^ 32'($signed(hmix_reg[j]) >>> 16);
        end
        for (int k = 0; k < 2; k++) s_full[k] = 37'(u3_reg[k]) * 37'(q16b_reg[k]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) hash_reg[j] <= hfin[j][HASH_W-1:0];
            for (int k = 0; k < 2; k++) s_reg[k] <= s_full[k][32:16];
        end
    end

    // stage 5: blend along x
    logic signed [31:0] dxa, dxb;
    logic signed [49:0] pxa, pxb;
    logic [31:0] a_reg, b_reg;
    logic [16:0] sz_reg;

    always_comb begin
        dxa = $signed({1'b0, hash_reg[1]}) - $signed({1'b0, hash_reg[0]});
        dxb = $signed({1'b0, hash_reg[3]}) - $signed({1'b0, hash_reg[2]});
        pxa = dxa * $signed({1'b0, s_reg[0]});
        pxb = dxb * $signed({1'b0, s_reg[0]});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= {1'b0, hash_reg[0]} + pxa[47:16];
            b_reg  <= {1'b0, hash_reg[2]} + pxb[47:16];
            sz_reg <= s_reg[1];
        end
    end

    // stage 6: blend along z
    logic signed [31:0] dz;
    logic signed [49:0] pz;
    logic [31:0] v_full;
    logic [HASH_W-1:0] v_reg;

    always_comb begin
        dz     = $signed(b_reg) - $signed(a_reg);
        pz     = dz * $signed({1'b0, sz_reg});
        v_full = a_reg + pz[47:16];
    end

    always_ff @(posedge aclk) begin
        if (en) v_reg <= v_full[HASH_W-1:0];
    end

    assign value = v_reg;

endmodule

`default_nettype wire

// File: rtl/fbmvn_layer.sv
`default_nettype none

module fbmvn_layer (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [31:0]       x,
    input  logic signed [31:0]       z,
    input  fbmvn_pkg::layer_cfg_t    cfg,
    output logic signed [31:0]       value
);
    import fbmvn_pkg::*;

    // scaled coordinate, octave 0
    logic signed [PROD_W-1:0] px_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg <= x * $signed({1'b0, cfg.freq});
            pz_reg <= z * $signed({1'b0, cfg.freq});
        end
    end

    logic signed [63:0] px_ext, pz_ext;
    assign px_ext = 64'(px_reg);
    assign pz_ext = 64'(pz_reg);

    logic [OCT_W-1:0] n_oct;
    assign n_oct = sat_octaves(cfg.octaves);

    logic [HASH_W-1:0]  oct_value [MAX_OCTAVES];
    logic signed [33:0] term [MAX_OCTAVES];

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        logic signed [63:0] cx_full, cz_full;
        logic signed [33:0] centered;

        assign cx_full = px_ext >>> (CELL_SHIFT - g);
        assign cz_full = pz_ext >>> (CELL_SHIFT - g);

        fbmvn_noise u_noise (
            .aclk   (aclk),
            .en     (en),
            .cell_x (cx_full[31:0]),
            .cell_z (cz_full[31:0]),
            .frac_x (px_reg[CELL_SHIFT-1-g -: FRAC_W]),
            .frac_z (pz_reg[CELL_SHIFT-1-g -: FRAC_W]),
            .value  (oct_value[g])
        );

        // 2v - 1 scaled by the octave amplitude
        assign centered = $signed({2'b00, oct_value[g], 1'b0}) - 34'sd2147483648;
        assign term[g]  = (OCT_W'(g) < n_oct) ? (centered >>> (g + 1)) : 34'sd0;
    end

    // two-level adder tree
    logic signed [33:0] pair_reg [MAX_OCTAVES/2];
    logic signed [33:0] sum_reg;
    logic signed [33:0] sum_next;

    always_comb begin
        sum_next = '0;
        for (int j = 0; j < MAX_OCTAVES/2; j++) sum_next = sum_next + pair_reg[j];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < MAX_OCTAVES/2; j++) begin
                pair_reg[j] <= term[2*j] + term[2*j+1];
            end
            sum_reg <= sum_next;
        end
    end

    // normalize and clamp
    logic signed [66:0] norm_reg;
    logic signed [36:0] norm_shift;
    logic signed [31:0] clamp_next;
    logic signed [31:0] value_reg;

    always_comb begin
        norm_shift = norm_reg[66:30];
        priority if (norm_shift > 37'sd2147483647) begin
            clamp_next = 32'sh7fffffff;
        end else if (norm_shift < -37'sd2147483648) begin
            clamp_next = 32'sh80000000;
        end else begin
            clamp_next = norm_shift[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm_reg  <= sum_reg * $signed({1'b0, recip_q30(n_oct)});
            value_reg <= clamp_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// File: rtl/fbmvn_shape.sv
`default_nettype none

module fbmvn_shape (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [31:0]    mask_raw,
    input  logic signed [31:0]    hills,
    input  fbmvn_pkg::shape_cfg_t cfg,
    output logic signed [16:0]    height
);
    import fbmvn_pkg::*;

    // mapped mask and smoothstep case select
    logic [15:0] m_map;
    t_sel_t      sel_next;
    logic [15:0] rem_next, den_next;

    always_comb begin
        m_map    = {~mask_raw[31], mask_raw[30:16]};
        rem_next = '0;
        den_next = cfg.edge_high - cfg.edge_low;
        priority if (cfg.edge_high <= cfg.edge_low) begin
            sel_next = (m_map >= cfg.edge_low) ? T_FULL : T_ZERO;
        end else if (m_map <= cfg.edge_low) begin
            sel_next = T_ZERO;
        end else if (m_map >= cfg.edge_high) begin
            sel_next = T_FULL;
        end else begin
            sel_next = T_DIV;
            rem_next = m_map - cfg.edge_low;
        end
    end

    // restoring divider, one quotient bit per stage
    logic [15:0] rem_reg [DIV_STEPS+1];
    logic [15:0] den_reg [DIV_STEPS+1];
    logic [15:0] quo_reg [DIV_STEPS+1];
    t_sel_t      sel_reg [DIV_STEPS+1];
    logic signed [31:0] hills_reg [HILL_DELAY];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= rem_next;
            den_reg[0] <= den_next;
            quo_reg[0] <= '0;
            sel_reg[0] <= sel_next;
            hills_reg[0] <= hills;
            for (int k = 1; k < HILL_DELAY; k++) hills_reg[k] <= hills_reg[k-1];
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [16:0] shifted;
        logic        fits;

        assign shifted = {rem_reg[k], 1'b0};
        assign fits    = shifted >= {1'b0, den_reg[k]};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= fits ? 16'(shifted - {1'b0, den_reg[k]}) : shifted[15:0];
                quo_reg[k+1] <= {quo_reg[k][14:0], fits};
                den_reg[k+1] <= den_reg[k];
                sel_reg[k+1] <= sel_reg[k];
            end
        end
    end

    // smoothstep t*t*(3-2t)
    logic [16:0] t_val;
    logic [33:0] tt_full;
    logic [16:0] t_reg, tt_reg;
    logic [17:0] poly;
    logic [34:0] mask_full;
    logic [16:0] mask_reg;

    always_comb begin
        unique case (sel_reg[DIV_STEPS])
            T_ZERO:  t_val = 17'd0;
            T_FULL:  t_val = 17'd65536;
            T_DIV:   t_val = {1'b0, quo_reg[DIV_STEPS]};
            default: t_val = 17'd0;
        endcase
        tt_full   = 34'(t_val) * 34'(t_val);
        poly      = 18'd196608 - {t_reg, 1'b0};
        mask_full = 35'(tt_reg) * 35'(poly);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= t_val;
            tt_reg   <= tt_full[32:16];
            mask_reg <= mask_full[32:16];
        end
    end

    // hills times mask times peak
    logic signed [49:0] hm_full;
    logic signed [32:0] hm_reg;
    logic signed [49:0] hp_reg;
    logic signed [18:0] h_shift;

    assign hm_full = hills_reg[HILL_DELAY-1] * $signed({1'b0, mask_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            hm_reg <= hm_full[48:16];
            hp_reg <= hm_reg * $signed({1'b0, cfg.peak});
        end
    end

    always_comb begin
        h_shift = hp_reg[49:31];
        priority if (h_shift > 19'sd65535) begin
            height = 17'sd65535;
        end else if (h_shift < -19'sd65536) begin
            height = -17'sd65536;
        end else begin
            height = h_shift[16:0];
        end
    end

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import fbmvn_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd7;   // no register behind this index
    localparam int DRAIN_CYCLES = 40;           // pipeline is 32 deep plus skid
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] z;
    } coord_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_world_x = '0;
    logic signed [31:0] s_world_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [16:0] m_height;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_wdata = '0;

    // local copy of the register file used by the height predictor
    logic [23:0] mdl_mask_freq, mdl_hill_freq;
    logic [3:0]  mdl_mask_oct, mdl_hill_oct;
    logic [15:0] mdl_peak, mdl_edge_lo, mdl_edge_hi;

    coord_t             coords_to_send[$];
    logic signed [16:0] heights_due[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int errors = 0;
    int quiet_cycles = 0;
    logic s_took = 1'b0;

    fbm_value_noise_terrain_height_top i_dut (.*);

    always #6 aclk = ~aclk;

    // ---------------- height predictor ----------------

    // lattice hash, wrapping 32-bit multiplies with arithmetic shifts, low 31 bits
    function automatic longint lattice_hash31(bit [31:0] cx, bit [31:0] cz);
        bit [31:0] n;
        n = cx * HASH_MUL_X + cz * HASH_MUL_Z;
        n = (n ^ 32'($signed(n) >>> 13)) * HASH_MUL_MIX;
        n = n ^ 32'($signed(n) >>> 16);
        return longint'(n[30:0]);
    endfunction

    // 6t^5 - 15t^4 + 10t^3 in q0.16, each step truncated
    function automatic longint fade_q16(longint u);
        longint q, u3;
        q = 6 * u * u - 15 * u * 65536 + 10 * (longint'(1) << 32);
        u3 = (((u * u) >>> 16) * u) >>> 16;
        return (u3 * (q >>> 16)) >>> 16;
    endfunction

    // bilinear value noise at a q.36 point, result q0.31
    function automatic longint lattice_noise(longint px, longint pz);
        longint cx, cz, sx, sz, a, b;
        bit [31:0] x0, z0;
        cx = px >>> 36;
        cz = pz >>> 36;
        sx = fade_q16((px - (cx <<< 36)) >>> 20);
        sz = fade_q16((pz - (cz <<< 36)) >>> 20);
        x0 = cx[31:0];
        z0 = cz[31:0];
        a = lattice_hash31(x0, z0);
        a = a + (((lattice_hash31(x0 + 1, z0) - a) * sx) >>> 16);
        b = lattice_hash31(x0, z0 + 1);
        b = b + (((lattice_hash31(x0 + 1, z0 + 1) - b) * sx) >>> 16);
        return a + (((b - a) * sz) >>> 16);
    endfunction

    function automatic longint octave_recip(int n);
        case (n)
            1: return 64'd2147483648;
            2: return 64'd1431655765;
            3: return 64'd1227133513;
            4: return 64'd1145324612;
            5: return 64'd1108378657;
            6: return 64'd1090785345;
            7: return 64'd1082196484;
            8: return 64'd1077952576;
            default: return 0;
        endcase
    endfunction

    function automatic longint fractal_sum(longint x, longint z, logic [23:0] freq,
                                           logic [3:0] octs);
        int n;
        longint sum, mul, v, r;
        n = (octs > MAX_OCTAVES) ? MAX_OCTAVES : int'(octs);
        sum = 0;
        if (n == 0) return 0;
        for (int i = 0; i < n; i++) begin
            mul = longint'(freq) << i;
            v = lattice_noise(x * mul, z * mul);
            sum += (2 * v - (longint'(1) << 31)) >>> (i + 1);
        end
        r = (sum * octave_recip(n)) >>> 30;
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r;
    endfunction

    // smoothstep of the mapped mask, or a step when the edges are not ordered
    function automatic longint mask_weight(longint m);
        longint e0, e1, t;
        e0 = mdl_edge_lo;
        e1 = mdl_edge_hi;
        if (e1 <= e0) return (m >= e0) ? 65536 : 0;
        if (m <= e0) t = 0;
        else if (m >= e1) t = 65536;
        else t = ((m - e0) << 16) / (e1 - e0);
        return (((t * t) >>> 16) * (3 * 65536 - 2 * t)) >>> 16;
    endfunction

    function automatic logic signed [16:0] terrain_height(coord_t c);
        longint m, hills, h;
        m = (fractal_sum(c.x, c.z, mdl_mask_freq, mdl_mask_oct) + (longint'(1) << 31)) >>> 16;
        hills = fractal_sum(c.x, c.z, mdl_hill_freq, mdl_hill_oct);
        h = (((hills * mask_weight(m)) >>> 16) * longint'(mdl_peak)) >>> 31;
        if (h > 65535) h = 65535;
        if (h < -65536) h = -65536;
        return h[16:0];
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch @%0t: %s", $realtime, what);
        errors++;
    endtask

    // ---------------- driver: inputs change on the falling edge ----------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_took) begin
                if (coords_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    coord_t c;
                    c = coords_to_send.pop_front();
                    s_valid   <= 1'b1;
                    s_world_x <= c.x;
                    s_world_z <= c.z;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- monitor: sample on the rising edge ----------------
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                coord_t c;
                c.x = s_world_x;
                c.z = s_world_z;
                heights_due.push_back(terrain_height(c));
            end
            if (m_valid && m_ready) begin
                if (heights_due.size() == 0)
                    report_mismatch($sformatf("unexpected height %0d", m_height));
                else begin
                    logic signed [16:0] want;
                    want = heights_due.pop_front();
                    if (m_height !== want)
                        report_mismatch($sformatf("height %0d, want %0d", m_height, want));
                end
            end
        end
    end

    // ---------------- watchdog: cycles with work pending but no transfer ----------------
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) ||
            (coords_to_send.size() == 0 && heights_due.size() == 0 && !s_valid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------

    // register write, mirrored into the predictor copy
    task automatic write_reg(logic [2:0] idx, logic [23:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_MASK_FREQ:      mdl_mask_freq = data;
            CFG_HILL_FREQ:      mdl_hill_freq = data;
            CFG_MASK_OCTAVES:   mdl_mask_oct  = data[3:0];
            CFG_HILL_OCTAVES:   mdl_hill_oct  = data[3:0];
            CFG_PEAK_HEIGHT:    mdl_peak      = data[15:0];
            CFG_MASK_EDGE_LOW:  mdl_edge_lo   = data[15:0];
            CFG_MASK_EDGE_HIGH: mdl_edge_hi   = data[15:0];
            default: ;  // out-of-range index is dropped by the block
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_coord(logic signed [31:0] x, logic signed [31:0] z);
        coord_t c;
        c.x = x;
        c.z = z;
        coords_to_send.push_back(c);
    endtask

    // wait for every expected height, then let the pipeline settle
    task automatic wait_drained();
        wait (coords_to_send.size() == 0 && heights_due.size() == 0 && !s_valid);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        logic signed [31:0] x, z;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                // a few hundred world units around the origin
                x = $signed($urandom_range(2097151)) - 32'sd1048576;
                z = $signed($urandom_range(2097151)) - 32'sd1048576;
            end else if (pick < 85) begin
                x = $urandom;
                z = $urandom;
            end else begin
                // near the edges of the coordinate range
                x = ($urandom_range(1) ? 32'h7fffffff : 32'h80000000) ^ $urandom_range(4095);
                z = ($urandom_range(1) ? 32'h7fffffff : 32'h80000000) ^ $urandom_range(4095);
            end
            queue_coord(x, z);
        end
    endtask

    // one random run under a given idling mix
    task automatic run_phase(int mode, int count);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
        endcase
        queue_random(count);
        wait_drained();
    endtask

    initial begin
        mdl_mask_freq = 24'd111848;
        mdl_hill_freq = 24'd186414;
        mdl_mask_oct  = 4'd3;
        mdl_hill_oct  = 4'd4;
        mdl_peak      = 16'd4608;
        mdl_edge_lo   = 16'd22938;
        mdl_edge_hi   = 16'd42598;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed coordinates under the reset settings
        queue_coord(0, 0);
        queue_coord(32'sh7fffffff, 32'sh7fffffff);
        queue_coord(32'sh80000000, 32'sh80000000);
        queue_coord(32'sh7fffffff, 32'sh80000000);
        queue_coord(32'sh80000000, 32'sh7fffffff);
        queue_coord(-1, -1);
        queue_coord(1, 1);
        queue_coord(4096, -4096);
        queue_coord(32'sh00555555, 32'shffaaaaab);
        queue_coord(32'sh0aaaaaaa, 32'sh05555555);
        wait_drained();

        // extremes: max frequency and octaves, octave count above the limit
        write_reg(CFG_MASK_FREQ, 24'hffffff);
        write_reg(CFG_HILL_FREQ, 24'hffffff);
        write_reg(CFG_MASK_OCTAVES, 24'd8);
        write_reg(CFG_HILL_OCTAVES, 24'd15);
        write_reg(CFG_PEAK_HEIGHT, 24'hffff);
        write_reg(CFG_MASK_EDGE_LOW, 24'd0);
        write_reg(CFG_MASK_EDGE_HIGH, 24'hffff);
        queue_coord(32'sh7fffffff, 32'sh80000000);
        queue_coord(-1, 1);
        run_phase(0, 150);

        // zero frequency and zero octaves, unordered edges make a step
        write_reg(CFG_MASK_FREQ, 24'd0);
        write_reg(CFG_HILL_FREQ, 24'd1);
        write_reg(CFG_MASK_OCTAVES, 24'd0);
        write_reg(CFG_HILL_OCTAVES, 24'd1);
        write_reg(CFG_MASK_EDGE_LOW, 24'd40000);
        write_reg(CFG_MASK_EDGE_HIGH, 24'd40000);
        run_phase(1, 150);

        // step mask with equal edges at zero, full peak to hit saturation
        write_reg(CFG_MASK_FREQ, 24'd111848);
        write_reg(CFG_MASK_OCTAVES, 24'd2);
        write_reg(CFG_HILL_FREQ, 24'd186414);
        write_reg(CFG_HILL_OCTAVES, 24'd1);
        write_reg(CFG_MASK_EDGE_LOW, 24'd0);
        write_reg(CFG_MASK_EDGE_HIGH, 24'd0);
        write_reg(CFG_UNUSED, 24'hffffff);
        run_phase(2, 150);

        // reset-like settings with zero peak, then back to the defaults
        write_reg(CFG_MASK_EDGE_LOW, 24'd22938);
        write_reg(CFG_MASK_EDGE_HIGH, 24'd42598);
        write_reg(CFG_PEAK_HEIGHT, 24'd0);
        write_reg(CFG_HILL_OCTAVES, 24'd4);
        run_phase(3, 120);
        write_reg(CFG_PEAK_HEIGHT, 24'd4608);
        write_reg(CFG_MASK_OCTAVES, 24'd3);

        // random register settings, the runs cycling through the idling mixes
        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_MASK_FREQ, 24'($urandom_range(24'hffffff, 1)));
            write_reg(CFG_HILL_FREQ, 24'($urandom_range(24'hffffff, 1)));
            write_reg(CFG_MASK_OCTAVES, 24'($urandom_range(8, 1)));
            write_reg(CFG_HILL_OCTAVES, 24'($urandom_range(8, 1)));
            write_reg(CFG_PEAK_HEIGHT, 24'($urandom_range(16'hffff)));
            write_reg(CFG_MASK_EDGE_LOW, 24'($urandom_range(16'hffff)));
            write_reg(CFG_MASK_EDGE_HIGH, 24'($urandom_range(16'hffff)));
            run_phase(p, 120);
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/fbmvn_pkg.sv
rtl/fbmvn_noise.sv
rtl/fbmvn_layer.sv
rtl/fbmvn_shape.sv
rtl/fbm_value_noise_terrain_height_top.sv
bench/tb.sv
